>>> hdl/neighbor_table_mtf_lookup_top_macros.svh
// Assertion macros for the checker file.
`ifndef NEIGHBOR_TABLE_MTF_LOOKUP_TOP_MACROS_SVH
`define NEIGHBOR_TABLE_MTF_LOOKUP_TOP_MACROS_SVH

// Assert a property on a given clock, disabled while the given reset is low.
`define NTML_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define NTML_ASSERT(lbl, prop, msg) `NTML_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/ntml_pkg.sv
package ntml_pkg;

  localparam int ID_W      = 8;
  localparam int TIME_W    = 32;
  localparam int CNT_OUT_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 1'b1;

  localparam logic [ID_W-1:0] OWN_ADDR_RESET   = 8'h00;
  localparam logic [ID_W-1:0] BCAST_ADDR_RESET = 8'hFF;
  localparam logic [ID_W-1:0] ID_NONE          = 8'h00;

  typedef enum logic [1:0] {
    ACT_SEEN   = 2'd0,
    ACT_NEXT   = 2'd1,
    ACT_PREV   = 2'd2,
    ACT_LOWEST = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUBLISH
  } state_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } ctrl_sts_t;

endpackage

>>> hdl/neighbor_table_mtf_lookup_top.sv
// Scan: a query or a missing id walks all N entries before the result, where N is the entry count;
//   an id found at slot a ends the walk at that slot.
// Throughput: one item at a time; the next is taken the cycle after the result is registered.
//   The table RAM is walked one entry per cycle through its registered read port.
// Reset: control, entry count and registers (own 0, broadcast 255) clear at once; table
//   contents stay undefined and are never used before written, so there is no clearing pass.
module neighbor_table_mtf_lookup_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ntml_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ntml_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [ntml_pkg::ID_W-1:0]          node_id_i,
  input  logic [ntml_pkg::ID_W-1:0]          dest_id_i,
  input  logic [ntml_pkg::TIME_W-1:0]        now_ms_i,
  input  logic [ntml_pkg::TIME_W-1:0]        live_span_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ntml_pkg::ID_W-1:0]          answer_id_o,
  output logic                               for_us_o,
  output logic [ntml_pkg::CNT_OUT_W-1:0]     entry_count_o
);

  import ntml_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ntml_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ntml_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .node_id_i      (node_id_i),
    .dest_id_i      (dest_id_i),
    .now_ms_i       (now_ms_i),
    .live_span_ms_i (live_span_ms_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .answer_id_o    (answer_id_o),
    .for_us_o       (for_us_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

>>> hdl/ntml_ram.sv
module ntml_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ntml_ctrl.sv
module ntml_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ntml_pkg::ctrl_cmd_t cmd_o,
  input  ntml_pkg::ctrl_sts_t sts_i
);

  import ntml_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequence one item: take it, walk the table, publish the result
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          state_d = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Set output valid on load, drop it once the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/ntml_dp.sv
module ntml_dp #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ntml_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ntml_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic [1:0]                            action_i,
  input  logic [ntml_pkg::ID_W-1:0]             node_id_i,
  input  logic [ntml_pkg::ID_W-1:0]             dest_id_i,
  input  logic [ntml_pkg::TIME_W-1:0]           now_ms_i,
  input  logic [ntml_pkg::TIME_W-1:0]           live_span_ms_i,
  input  ntml_pkg::ctrl_cmd_t                   cmd_i,
  output ntml_pkg::ctrl_sts_t                   sts_o,
  output logic [ntml_pkg::ID_W-1:0]             answer_id_o,
  output logic                                  for_us_o,
  output logic [ntml_pkg::CNT_OUT_W-1:0]        entry_count_o
);

  import ntml_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int ENT_W = $bits(entry_t);

  // Configuration registers
  logic [ID_W-1:0] own_q, bcast_q;

  // Item context
  action_e           op_q;
  logic [ID_W-1:0]   key_q, ref_q, ret_q;
  entry_t            carry_q;
  logic [TIME_W-1:0] allowed_q;
  logic              for_us_q;
  logic [AW-1:0]     idx_q, count_q;

  // Result register
  logic [ID_W-1:0]      answer_q;
  logic                 for_us_out_q;
  logic [CNT_OUT_W-1:0] entry_count_q;

  logic [ID_W-1:0]      ref_sel, init_ret, ret_n;
  logic [TIME_W-1:0]    allowed;
  logic [ENT_W-1:0]     rd_data;
  entry_t               rd_entry;
  logic                 at_end, hit, live, is_seen, done;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [AW+CNT_OUT_W-1:0] count_ext;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= OWN_ADDR_RESET;
      bcast_q <= BCAST_ADDR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OWN_ADDR:   own_q   <= cfg_data_i;
        CFG_BCAST_ADDR: bcast_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Resolve reference, seed answer from own address, compute live threshold
  always_comb begin
    ref_sel  = (node_id_i == ID_NONE) ? own_q : node_id_i;
    init_ret = ID_NONE;
    if (action_i == ACT_NEXT) begin
      init_ret = (own_q > ref_sel) ? own_q : ID_NONE;
    end else if (action_i != ACT_SEEN) begin
      init_ret = (own_q < ref_sel) ? own_q : ID_NONE;
    end
    allowed = (now_ms_i > live_span_ms_i) ? (now_ms_i - live_span_ms_i) : '0;
  end

  // Compare the entry read back against the item
  assign rd_entry = entry_t'(rd_data);
  assign at_end   = (idx_q == count_q);
  assign hit      = (rd_entry.id == key_q);
  assign live     = (rd_entry.seen >= allowed_q);
  assign is_seen  = (op_q == ACT_SEEN);
  assign done     = at_end || (is_seen && hit);
  assign sts_o.done = done;

  // Fold one entry into the running answer
  always_comb begin
    ret_n = ret_q;
    unique case (op_q)
      ACT_NEXT: begin
        if (rd_entry.id > ref_q && (ret_q == ID_NONE || rd_entry.id < ret_q)) begin
          ret_n = rd_entry.id;
        end
      end
      ACT_PREV: begin
        if (rd_entry.id < ref_q && (ret_q == ID_NONE || rd_entry.id > ret_q)) begin
          ret_n = rd_entry.id;
        end
      end
      ACT_LOWEST: begin
        if (rd_entry.id < ref_q && (ret_q == ID_NONE || rd_entry.id < ret_q)) begin
          ret_n = rd_entry.id;
        end
      end
      ACT_SEEN: begin
        ret_n = ret_q;
      end
    endcase
  end

  // Latch the item, then advance one entry per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= action_e'(action_i);
      key_q     <= node_id_i;
      ref_q     <= ref_sel;
      carry_q   <= '{id: node_id_i, seen: now_ms_i};
      allowed_q <= allowed;
      ret_q     <= init_ret;
      for_us_q  <= (action_i == ACT_SEEN) && (dest_id_i == own_q || dest_id_i == bcast_q);
      idx_q     <= '0;
    end else if (cmd_i.step && !done) begin
      idx_q <= idx_q + AW'(1);
      if (is_seen) begin
        carry_q <= rd_entry;
      end else if (live) begin
        ret_q <= ret_n;
      end
    end
  end

  // Grow the table on a miss until it saturates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.step && is_seen && at_end && count_q != AW'(DEPTH - 1)) begin
      count_q <= count_q + AW'(1);
    end
  end

  // Load the result register
  assign count_ext = {{CNT_OUT_W{1'b0}}, count_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      answer_q      <= ret_q;
      for_us_out_q  <= for_us_q;
      entry_count_q <= count_ext[CNT_OUT_W-1:0];
    end
  end

  assign answer_id_o   = answer_q;
  assign for_us_o      = for_us_out_q;
  assign entry_count_o = entry_count_q;

  // Shift the carried entry back one slot per step; read the next slot ahead
  assign ram_we    = cmd_i.step && is_seen;
  assign ram_re    = cmd_i.start || cmd_i.step;
  assign ram_raddr = cmd_i.start ? '0 : (idx_q + AW'(1));

  ntml_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (carry_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

endmodule

>>> hdl/ntml_checker.sv
`include "neighbor_table_mtf_lookup_top_macros.svh"

module ntml_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ntml_pkg::ID_W-1:0]      answer_id_o
  , input logic                         for_us_o
);

  // Hold a stalled result
  `NTML_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(answer_id_o), "stalled result changed")

  // Seen results carry no answer, query results are never for us
  `NTML_ASSERT(a_excl, out_valid_o |-> !(for_us_o && answer_id_o != 8'h00), "answer and for_us both set")

  // Go busy right after taking an item
  `NTML_ASSERT(a_busy, in_valid_i && !in_stall_o |=> in_stall_o, "not busy after accept")

  // Publish a new result only from the busy phase
  `NTML_ASSERT(a_pub, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared while idle")

endmodule

bind neighbor_table_mtf_lookup_top ntml_checker u_checker (.*);

>>> verif/neighbor_table_mtf_lookup_top_tb.sv
`timescale 1ns / 100ps

module neighbor_table_mtf_lookup_top_tb;
  import ntml_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int DRAIN_CYCLES   = TABLE_DEPTH + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE      = 24;

  typedef struct {
    logic [ID_W-1:0]      answer_id;
    logic                 for_us;
    logic [CNT_OUT_W-1:0] entry_count;
  } lookup_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // Mirror of the neighbor table plus the queue of lookups still to come out
  class neighbor_scoreboard;
    logic [ID_W-1:0]   own_addr;
    logic [ID_W-1:0]   bcast_addr;
    logic [ID_W-1:0]   heard_ids[TABLE_DEPTH];
    logic [TIME_W-1:0] heard_ms[TABLE_DEPTH];
    int unsigned       heard_count;
    lookup_result_t    expected_q[$];
    int unsigned       mismatches;

    function new();
      own_addr    = OWN_ADDR_RESET;
      bcast_addr  = BCAST_ADDR_RESET;
      heard_count = 0;
      mismatches  = 0;
      foreach (heard_ids[i]) begin
        heard_ids[i] = '0;
        heard_ms[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_W-1:0] value);
      if (reg_index == CFG_OWN_ADDR) begin
        own_addr = value;
      end else begin
        bcast_addr = value;
      end
    endfunction

    function void note_item(action_e act, logic [ID_W-1:0] node, logic [ID_W-1:0] dest,
                            logic [TIME_W-1:0] now, logic [TIME_W-1:0] span);
      lookup_result_t    res;
      int unsigned       slot;
      logic [TIME_W-1:0] oldest_ok;
      logic [ID_W-1:0]   ref_id;
      logic [ID_W-1:0]   best;
      res.answer_id = ID_NONE;
      res.for_us    = 1'b0;
      if (act == ACT_SEEN) begin
        // find the id; a miss lands one past the last entry
        slot = 0;
        while (slot < heard_count && heard_ids[slot] != node) slot++;
        if (slot == heard_count && heard_count < TABLE_DEPTH - 1) heard_count++;
        // push the entries ahead of it back one place, then put it at the front
        for (int i = int'(slot); i > 0; i--) begin
          heard_ids[i] = heard_ids[i-1];
          heard_ms[i]  = heard_ms[i-1];
        end
        heard_ids[0] = node;
        heard_ms[0]  = now;
        res.for_us   = (dest == own_addr) || (dest == bcast_addr);
      end else begin
        oldest_ok = (now > span) ? now - span : '0;
        ref_id    = (node == ID_NONE) ? own_addr : node;
        if (act == ACT_NEXT) begin
          best = (own_addr > ref_id) ? own_addr : ID_NONE;
        end else begin
          best = (own_addr < ref_id) ? own_addr : ID_NONE;
        end
        // reduce over the live entries only
        for (int i = 0; i < int'(heard_count); i++) begin
          if (heard_ms[i] >= oldest_ok) begin
            case (act)
              ACT_NEXT: begin
                if (heard_ids[i] > ref_id && (best == ID_NONE || heard_ids[i] < best))
                  best = heard_ids[i];
              end
              ACT_PREV: begin
                if (heard_ids[i] < ref_id && (best == ID_NONE || heard_ids[i] > best))
                  best = heard_ids[i];
              end
              default: begin
                if (heard_ids[i] < ref_id && (best == ID_NONE || heard_ids[i] < best))
                  best = heard_ids[i];
              end
            endcase
          end
        end
        res.answer_id = best;
      end
      res.entry_count = CNT_OUT_W'(heard_count);
      expected_q.push_back(res);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no item waiting: answer_id %0d for_us %0d entry_count %0d",
               got.answer_id, got.for_us, got.entry_count);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.answer_id !== want.answer_id) begin
        $error("answer_id: expected %0d, actual %0d", want.answer_id, got.answer_id);
        mismatches++;
      end
      if (got.for_us !== want.for_us) begin
        $error("for_us: expected %0d, actual %0d", want.for_us, got.for_us);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           action_i       = ACT_SEEN;
  logic [ID_W-1:0]      node_id_i      = '0;
  logic [ID_W-1:0]      dest_id_i      = '0;
  logic [TIME_W-1:0]    now_ms_i       = '0;
  logic [TIME_W-1:0]    live_span_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [ID_W-1:0]      answer_id_o;
  logic                 for_us_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  neighbor_scoreboard sb = new();

  logic [TIME_W-1:0] clock_ms;
  logic [ID_W-1:0]   id_pool[POOL_SIZE];
  bit                hold_request = 1'b0;

  neighbor_table_mtf_lookup_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (.*);

  always #4 clk_i = ~clk_i;

  // Offer one item and hold it until the block takes it
  task automatic offer_item(action_e act, logic [ID_W-1:0] node, logic [ID_W-1:0] dest,
                            logic [TIME_W-1:0] now, logic [TIME_W-1:0] span);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    node_id_i      <= node;
    dest_id_i      <= dest;
    now_ms_i       <= now;
    live_span_ms_i <= span;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_item(act, node, dest, now, span);
  endtask

  task automatic idle_for(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.write_reg(reg_index, value);
  endtask

  // Write both addresses while idle, then pick a new id mix and time base
  task automatic reconfigure(logic [CFG_W-1:0] own, logic [CFG_W-1:0] bcast);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_cfg(CFG_OWN_ADDR, own);
    write_cfg(CFG_BCAST_ADDR, bcast);
    cfg_we_i <= 1'b0;
    foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(0, 255));
    id_pool[0] = own;
    case ($urandom_range(0, 2))
      0:       clock_ms = $urandom_range(0, 500);
      1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: clock_ms = $urandom();
    endcase
  endtask

  task automatic send_random_item();
    action_e           act;
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   dest;
    logic [TIME_W-1:0] span;
    int unsigned       pick;
    // advance time, with an occasional jump anywhere
    if ($urandom_range(0, 99) < 3) begin
      clock_ms = $urandom();
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 40);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) act = ACT_SEEN;
    else if (pick < 70) act = ACT_NEXT;
    else if (pick < 85) act = ACT_PREV;
    else act = ACT_LOWEST;
    pick = $urandom_range(0, 99);
    if (act == ACT_SEEN) begin
      node = (pick < 90) ? id_pool[$urandom_range(0, POOL_SIZE-1)]
                         : 8'($urandom_range(0, 255));
    end else if (pick < 30) begin
      node = id_pool[$urandom_range(0, POOL_SIZE-1)];
    end else if (pick < 45) begin
      node = ID_NONE;
    end else if (pick < 55) begin
      node = sb.own_addr;
    end else if (pick < 65) begin
      node = 8'hFF;
    end else begin
      node = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) dest = sb.own_addr;
    else if (pick < 60) dest = sb.bcast_addr;
    else dest = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) span = $urandom_range(0, 300);
    else if (pick < 55) span = $urandom_range(0, 3000);
    else if (pick < 70) span = $urandom();
    else if (pick < 85) span = clock_ms + $urandom_range(0, 100);
    else span = '0;
    offer_item(act, node, dest, clock_ms, span);
  endtask

  // Send items in bursts of random length, some back to back
  task automatic send_random_items(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        send_random_item();
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
    end
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items with the reset addresses
    offer_item(ACT_SEEN, 8'd0, 8'd0, 32'd100, 32'd0);
    offer_item(ACT_SEEN, 8'hFF, 8'hFF, 32'd110, 32'hFFFF_FFFF);
    offer_item(ACT_SEEN, 8'd7, 8'd9, 32'd120, 32'd0);
    // fill past the table's capacity of 15 entries so the oldest id drops out
    for (int k = 0; k < 13; k++) begin
      offer_item(ACT_SEEN, 8'(10 + k), 8'(k), 32'(130 + 10 * k), 32'd0);
    end
    // a known id moves to the front
    offer_item(ACT_SEEN, 8'hFF, 8'd3, 32'd300, 32'd0);
    offer_item(ACT_NEXT, ID_NONE, 8'd0, 32'd300, 32'd1_000_000);
    offer_item(ACT_PREV, 8'hFF, 8'd0, 32'd300, 32'd0);
    offer_item(ACT_LOWEST, 8'd200, 8'd0, 32'd300, 32'd175);
    offer_item(ACT_NEXT, 8'd254, 8'd0, 32'd400, 32'hFFFF_FFFF);
    offer_item(ACT_PREV, 8'd16, 8'hFF, 32'd400, 32'd1000);
    offer_item(ACT_LOWEST, 8'hFF, 8'd0, 32'd400, 32'd1000);
    offer_item(ACT_NEXT, 8'hFF, 8'd0, 32'd400, 32'd1000);

    // random phases, each under its own address setting
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       reconfigure(8'hFF, 8'h00);
        1:       reconfigure(8'h00, 8'hFF);
        2:       reconfigure(8'h80, 8'h80);
        3:       reconfigure(8'h01, 8'hFE);
        default: reconfigure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      if (phase == 1) begin
        // keep offering while the result side holds off
        hold_request = 1'b1;
        send_random_items(40);
      end
      if (phase == 3) begin
        send_random_items(100);
        wait_drained();
      end
      send_random_items(175);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Take results and stall on a changing pattern
  initial begin : result_sink
    stall_mode_e    mode;
    int             mode_left;
    int             hold_left;
    logic           take;
    lookup_result_t got;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      take            = rst_ni && out_valid_o === 1'b1 && !out_stall_i;
      got.answer_id   = answer_id_o;
      got.for_us      = for_us_o;
      got.entry_count = entry_count_o;
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      @(posedge clk_i);
      if (take) sb.check_result(got);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // End the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/ntml_pkg.sv
hdl/ntml_ram.sv
hdl/ntml_ctrl.sv
hdl/ntml_dp.sv
hdl/neighbor_table_mtf_lookup_top.sv
hdl/ntml_checker.sv
verif/neighbor_table_mtf_lookup_top_tb.sv
